// File: rtl/owsrl_pkg.sv
// Shared types, codes and reset values for the 1-Wire slave ROM command layer.
`default_nettype none

package owsrl_pkg;

  localparam int unsigned TIME_W     = 20;
  localparam int unsigned ROM_ID_W   = 64;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] REG_ROM_ID       = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RESET_THRESH = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_THRESH  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_THRESH   = 2'd3;

  localparam logic [TIME_W-1:0] RESET_THRESH_DEFAULT = 20'd205000;
  localparam logic [TIME_W-1:0] ZERO_THRESH_DEFAULT  = 20'd30000;
  localparam logic [TIME_W-1:0] ONE_THRESH_DEFAULT   = 20'd15000;

  localparam logic [7:0] CMD_READ_ROM   = 8'h33;
  localparam logic [7:0] CMD_MATCH_ROM  = 8'h55;
  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CMD_SEARCH_ROM = 8'hF0;

  localparam logic [4:0] PRESENCE_DELAY_US = 5'd20;
  localparam logic [6:0] PRESENCE_WIDTH_US = 7'd80;
  localparam logic [4:0] DATA_DELAY_US     = 5'd1;
  localparam logic [6:0] DATA_WIDTH_US     = 7'd25;

  localparam logic [5:0] LAST_BIT_BYTE  = 6'd7;
  localparam logic [5:0] LAST_BIT_ROM   = 6'd63;
  localparam logic [5:0] LAST_BIT_PAIR  = 6'd1;
  localparam logic [5:0] LAST_BIT_FIRST = 6'd0;
  localparam logic [3:0] ROM_BYTES      = 4'd8;
  localparam logic [6:0] SEARCH_BITS    = 7'd64;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ROM_CMD,
    PH_MATCH,
    PH_SEARCH,
    PH_FUN_CMD
  } phase_t;

  typedef struct packed {
    logic [ROM_ID_W-1:0] rom_id;
    logic [TIME_W-1:0]   reset_thresh;
    logic [TIME_W-1:0]   zero_thresh;
    logic [TIME_W-1:0]   one_thresh;
  } cfg_t;

  typedef struct packed {
    logic       selected;
    logic [7:0] byte_value;
    logic       byte_valid;
    logic [6:0] drive_width_us;
    logic [4:0] drive_delay_us;
    logic       drive_low;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/owsrl_cfg.sv
// Configuration register bank: device id and pulse thresholds.
`default_nettype none

module owsrl_cfg (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [owsrl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire [owsrl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output owsrl_pkg::cfg_t                    cfg
);

  owsrl_pkg::cfg_t cfg_r;
  owsrl_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        owsrl_pkg::REG_ROM_ID:       cfg_nxt.rom_id = cfg_wdata;
        owsrl_pkg::REG_RESET_THRESH:
          cfg_nxt.reset_thresh = cfg_wdata[owsrl_pkg::TIME_W-1:0];
        owsrl_pkg::REG_ZERO_THRESH:
          cfg_nxt.zero_thresh = cfg_wdata[owsrl_pkg::TIME_W-1:0];
        owsrl_pkg::REG_ONE_THRESH:
          cfg_nxt.one_thresh = cfg_wdata[owsrl_pkg::TIME_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rom_id       <= '0;
      cfg_r.reset_thresh <= owsrl_pkg::RESET_THRESH_DEFAULT;
      cfg_r.zero_thresh  <= owsrl_pkg::ZERO_THRESH_DEFAULT;
      cfg_r.one_thresh   <= owsrl_pkg::ONE_THRESH_DEFAULT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/owsrl_core.sv
// ROM command FSM: classifies one pulse per cycle on step and forms its result.
`default_nettype none

module owsrl_core (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              step,
  input  wire [owsrl_pkg::TIME_W-1:0]      low_time_ns,
  input  wire owsrl_pkg::cfg_t             cfg,
  output owsrl_pkg::res_t                  res
);

  owsrl_pkg::phase_t phase_r, phase_nxt;
  logic [5:0] bit_pos_r, bit_pos_nxt;
  logic [5:0] bit_last_r, bit_last_nxt;
  logic [7:0] rx_shift_r, rx_shift_nxt;
  logic [7:0] tx_byte_r, tx_byte_nxt;
  logic       tx_r, tx_nxt;
  logic [3:0] rom_left_r, rom_left_nxt;
  logic [6:0] search_pos_r, search_pos_nxt;
  logic       search_bit_r, search_bit_nxt;

  logic       do_rx;
  logic       do_tx;
  logic       rx_bit;
  logic       low_pos;
  logic [7:0] rx_new;
  logic [6:0] search_inc;
  logic       search_id_bit;
  logic [3:0] rom_left_dec;
  logic [2:0] rom_idx;
  logic       tx_bit;

  always_comb begin
    phase_nxt      = phase_r;
    bit_pos_nxt    = bit_pos_r;
    bit_last_nxt   = bit_last_r;
    rx_shift_nxt   = rx_shift_r;
    tx_byte_nxt    = tx_byte_r;
    tx_nxt         = tx_r;
    rom_left_nxt   = rom_left_r;
    search_pos_nxt = search_pos_r;
    search_bit_nxt = search_bit_r;
    res            = '0;
    do_rx          = 1'b0;
    do_tx          = 1'b0;
    rx_bit         = 1'b0;

    low_pos       = (bit_pos_r[5:3] == 3'd0);
    search_inc    = search_pos_r + 7'd1;
    search_id_bit = cfg.rom_id[search_inc[5:0]];
    rom_left_dec  = rom_left_r - 4'd1;
    rom_idx       = 3'(owsrl_pkg::ROM_BYTES - rom_left_dec);
    tx_bit        = low_pos ? tx_byte_r[bit_pos_r[2:0]] : 1'b1;

    if (low_time_ns > cfg.reset_thresh) begin
      rx_shift_nxt       = '0;
      bit_pos_nxt        = '0;
      bit_last_nxt       = owsrl_pkg::LAST_BIT_BYTE;
      tx_nxt             = 1'b0;
      rom_left_nxt       = '0;
      phase_nxt          = owsrl_pkg::PH_ROM_CMD;
      res.drive_low      = 1'b1;
      res.drive_delay_us = owsrl_pkg::PRESENCE_DELAY_US;
      res.drive_width_us = owsrl_pkg::PRESENCE_WIDTH_US;
    end else if (phase_r != owsrl_pkg::PH_IDLE) begin
      if (low_time_ns > cfg.zero_thresh) begin
        do_rx  = !tx_r;
        rx_bit = 1'b0;
      end else if (low_time_ns < cfg.one_thresh) begin
        do_tx  = tx_r;
        do_rx  = !tx_r;
        rx_bit = 1'b1;
      end
    end

    rx_new = rx_shift_r | ({7'd0, rx_bit & low_pos} << bit_pos_r[2:0]);

    if (do_rx) begin
      if (phase_r == owsrl_pkg::PH_MATCH && rx_bit != cfg.rom_id[bit_pos_r]) begin
        phase_nxt    = owsrl_pkg::PH_IDLE;
        rx_shift_nxt = '0;
        bit_pos_nxt  = '0;
        bit_last_nxt = owsrl_pkg::LAST_BIT_BYTE;
      end else if (bit_pos_r != bit_last_r) begin
        rx_shift_nxt = rx_new;
        bit_pos_nxt  = bit_pos_r + 6'd1;
      end else begin
        rx_shift_nxt = '0;
        bit_pos_nxt  = '0;
        bit_last_nxt = owsrl_pkg::LAST_BIT_BYTE;
        case (phase_r)
          owsrl_pkg::PH_ROM_CMD: begin
            case (rx_new)
              owsrl_pkg::CMD_READ_ROM: begin
                rom_left_nxt = owsrl_pkg::ROM_BYTES;
                tx_byte_nxt  = cfg.rom_id[7:0];
                tx_nxt       = 1'b1;
              end
              owsrl_pkg::CMD_MATCH_ROM: begin
                bit_last_nxt = owsrl_pkg::LAST_BIT_ROM;
                phase_nxt    = owsrl_pkg::PH_MATCH;
              end
              owsrl_pkg::CMD_SKIP_ROM: phase_nxt = owsrl_pkg::PH_FUN_CMD;
              owsrl_pkg::CMD_SEARCH_ROM: begin
                phase_nxt      = owsrl_pkg::PH_SEARCH;
                search_pos_nxt = '0;
                search_bit_nxt = cfg.rom_id[0];
                tx_byte_nxt    = cfg.rom_id[0] ? 8'd1 : 8'd2;
                bit_last_nxt   = owsrl_pkg::LAST_BIT_PAIR;
                tx_nxt         = 1'b1;
              end
              default: phase_nxt = owsrl_pkg::PH_IDLE;
            endcase
          end
          owsrl_pkg::PH_FUN_CMD: begin
            res.byte_valid = 1'b1;
            res.byte_value = rx_new;
          end
          owsrl_pkg::PH_MATCH: phase_nxt = owsrl_pkg::PH_FUN_CMD;
          owsrl_pkg::PH_SEARCH: begin
            if ((rx_new != 8'd0) != search_bit_r) begin
              phase_nxt = owsrl_pkg::PH_IDLE;
            end else begin
              search_pos_nxt = search_inc;
              if (search_inc >= owsrl_pkg::SEARCH_BITS) begin
                phase_nxt = owsrl_pkg::PH_FUN_CMD;
              end else begin
                search_bit_nxt = search_id_bit;
                tx_byte_nxt    = search_id_bit ? 8'd1 : 8'd2;
                bit_last_nxt   = owsrl_pkg::LAST_BIT_PAIR;
                tx_nxt         = 1'b1;
              end
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end

    if (do_tx) begin
      if (!tx_bit) begin
        res.drive_low      = 1'b1;
        res.drive_delay_us = owsrl_pkg::DATA_DELAY_US;
        res.drive_width_us = owsrl_pkg::DATA_WIDTH_US;
      end
      if (bit_pos_r != bit_last_r) begin
        bit_pos_nxt = bit_pos_r + 6'd1;
      end else begin
        bit_pos_nxt = '0;
        tx_nxt      = 1'b0;
        if (phase_r == owsrl_pkg::PH_SEARCH) begin
          bit_last_nxt = owsrl_pkg::LAST_BIT_FIRST;
        end else if (rom_left_r != 4'd0) begin
          rom_left_nxt = rom_left_dec;
          if (rom_left_dec == 4'd0) begin
            if (phase_r == owsrl_pkg::PH_ROM_CMD) begin
              phase_nxt = owsrl_pkg::PH_FUN_CMD;
            end else if (phase_r == owsrl_pkg::PH_FUN_CMD) begin
              phase_nxt = owsrl_pkg::PH_IDLE;
            end
          end else begin
            tx_byte_nxt  = cfg.rom_id[{rom_idx, 3'b000} +: 8];
            bit_last_nxt = owsrl_pkg::LAST_BIT_BYTE;
            tx_nxt       = 1'b1;
          end
        end
      end
    end

    res.selected = (phase_nxt == owsrl_pkg::PH_FUN_CMD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= owsrl_pkg::PH_IDLE;
      bit_pos_r    <= '0;
      bit_last_r   <= owsrl_pkg::LAST_BIT_BYTE;
      rx_shift_r   <= '0;
      tx_byte_r    <= '0;
      tx_r         <= 1'b0;
      rom_left_r   <= '0;
      search_pos_r <= '0;
      search_bit_r <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bit_pos_r    <= bit_pos_nxt;
      bit_last_r   <= bit_last_nxt;
      rx_shift_r   <= rx_shift_nxt;
      tx_byte_r    <= tx_byte_nxt;
      tx_r         <= tx_nxt;
      rom_left_r   <= rom_left_nxt;
      search_pos_r <= search_pos_nxt;
      search_bit_r <= search_bit_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/one_wire_slave_rom_layer_unit.sv
// Top level of the 1-Wire slave ROM command layer with input and result registers.
//
//   channel  direction  contents
//   in_*     slave      one finished low pulse length per item
//   out_*    master     one drive request, function byte and select flag per item
//   cfg_*    write      device id and three pulse thresholds
//
// One item is taken every cycle while the result side does not stall; an item
// goes into the input register, and the state update writes its result into the
// result register. Reset (rst_n low, synchronous) empties both registers and
// restores the idle phase and the default thresholds. A stalled result holds
// its register; the input register then takes an item only while it is empty.
`default_nettype none

module one_wire_slave_rom_layer_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [19:0] low_time_ns, [23:20] zero
  input  wire [owsrl_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [0] drive_low, [5:1] drive_delay_us, [12:6] drive_width_us, [13] byte_valid,
  // [21:14] byte_value, [22] selected, [23] zero
  output logic [owsrl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  wire                                 cfg_we,
  input  wire [owsrl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire [owsrl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  owsrl_pkg::cfg_t cfg;
  owsrl_pkg::res_t res;

  logic                          in_valid_r, in_valid_nxt;
  logic [owsrl_pkg::TIME_W-1:0]  in_data_r;
  logic                          out_valid_r, out_valid_nxt;
  owsrl_pkg::res_t               out_res_r;
  logic                          step;

  owsrl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  owsrl_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .low_time_ns (in_data_r),
    .cfg         (cfg),
    .res         (res)
  );

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata[owsrl_pkg::TIME_W-1:0];
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};

`ifndef SYNTHESIS
  a_byte_only_when_selected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.byte_valid |-> out_res_r.selected)
    else $error("function byte reported outside the function phase");

  a_idle_drive_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.drive_low |->
      out_res_r.drive_delay_us == 5'd0 && out_res_r.drive_width_us == 7'd0)
    else $error("drive timing set without a drive request");

  a_pending_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step |=> in_valid_r && $stable(in_data_r))
    else $error("pending input item lost or changed while stalled");
`endif

endmodule

`default_nettype wire

// File: tb/sv/one_wire_slave_rom_layer_unit_tb.sv
// Self-checking testbench for the 1-Wire slave ROM command layer: pulse stream in, results checked.
module one_wire_slave_rom_layer_unit_tb;

  localparam int unsigned TIME_MAX = 20'hFFFFF;
  localparam int QUIET_LIMIT = 600;
  localparam int REPORT_LIMIT = 40;
  localparam int CLS_RESET = 0;
  localparam int CLS_ZERO = 1;
  localparam int CLS_ONE = 2;
  localparam int CLS_GAP = 3;

  typedef enum int {
    SEQ_READ,
    SEQ_MATCH,
    SEQ_SEARCH,
    SEQ_SKIP,
    SEQ_UNKNOWN,
    SEQ_NOISE
  } seq_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [owsrl_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [owsrl_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [owsrl_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [owsrl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  one_wire_slave_rom_layer_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Register copies and bus state of the slave as the checker sees it.
  logic [63:0] dev_id;
  int unsigned thr_reset, thr_zero, thr_one;
  owsrl_pkg::phase_t ph;
  logic [5:0] bit_pos, last_bit;
  logic [7:0] rx_shift, tx_byte;
  logic tx_on;
  logic [3:0] id_bytes_left;
  logic [6:0] srch_pos;
  logic srch_true;
  owsrl_pkg::res_t pred_res;

  logic [owsrl_pkg::TIME_W-1:0] pending_pulses[$];
  owsrl_pkg::res_t pending_results[$];
  owsrl_pkg::res_t seen, want;
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;
  int calm_left[2] = '{0, 0};
  int quiet_cycles = 0;
  int n_queued = 0, n_accepted = 0, n_checked = 0, n_errors = 0;
  int n_presence = 0, n_pulls = 0, n_fun_bytes = 0, n_settings = 0;
  int seq_count[6] = '{0, 0, 0, 0, 0, 0};

  function automatic void reset_predictor();
    dev_id = '0;
    thr_reset = owsrl_pkg::RESET_THRESH_DEFAULT;
    thr_zero = owsrl_pkg::ZERO_THRESH_DEFAULT;
    thr_one = owsrl_pkg::ONE_THRESH_DEFAULT;
    ph = owsrl_pkg::PH_IDLE;
    bit_pos = '0;
    last_bit = owsrl_pkg::LAST_BIT_BYTE;
    rx_shift = '0;
    tx_byte = '0;
    tx_on = 1'b0;
    id_bytes_left = '0;
    srch_pos = '0;
    srch_true = 1'b0;
  endfunction

  function automatic void load_tx(input logic [7:0] data, input logic [5:0] last);
    tx_byte = data;
    bit_pos = '0;
    last_bit = last;
    tx_on = 1'b1;
  endfunction

  // A search step sends the id bit and then its complement, LSB first.
  function automatic void offer_search_bit();
    srch_true = dev_id[srch_pos[5:0]];
    load_tx(srch_true ? 8'd1 : 8'd2, owsrl_pkg::LAST_BIT_PAIR);
  endfunction

  function automatic void take_rom_cmd(input logic [7:0] cmd);
    case (cmd)
      owsrl_pkg::CMD_READ_ROM: begin
        id_bytes_left = owsrl_pkg::ROM_BYTES;
        load_tx(dev_id[7:0], owsrl_pkg::LAST_BIT_BYTE);
      end
      owsrl_pkg::CMD_MATCH_ROM: begin
        last_bit = owsrl_pkg::LAST_BIT_ROM;
        ph = owsrl_pkg::PH_MATCH;
      end
      owsrl_pkg::CMD_SKIP_ROM: ph = owsrl_pkg::PH_FUN_CMD;
      owsrl_pkg::CMD_SEARCH_ROM: begin
        ph = owsrl_pkg::PH_SEARCH;
        srch_pos = '0;
        offer_search_bit();
      end
      default: ph = owsrl_pkg::PH_IDLE;
    endcase
  endfunction

  function automatic void take_byte(input logic [7:0] rx);
    case (ph)
      owsrl_pkg::PH_ROM_CMD: take_rom_cmd(rx);
      owsrl_pkg::PH_FUN_CMD: begin
        pred_res.byte_valid = 1'b1;
        pred_res.byte_value = rx;
      end
      owsrl_pkg::PH_MATCH: ph = owsrl_pkg::PH_FUN_CMD;
      owsrl_pkg::PH_SEARCH: begin
        if ((rx != 8'd0) != srch_true) begin
          ph = owsrl_pkg::PH_IDLE;
        end else begin
          srch_pos = srch_pos + 7'd1;
          if (srch_pos >= owsrl_pkg::SEARCH_BITS) begin
            ph = owsrl_pkg::PH_FUN_CMD;
            last_bit = owsrl_pkg::LAST_BIT_BYTE;
          end else begin
            offer_search_bit();
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void take_bit(input logic b);
    logic [7:0] rx;
    if (ph == owsrl_pkg::PH_MATCH && b != dev_id[bit_pos]) begin
      ph = owsrl_pkg::PH_IDLE;
      rx_shift = '0;
      bit_pos = '0;
      last_bit = owsrl_pkg::LAST_BIT_BYTE;
    end else begin
      if (b && bit_pos < 6'd8) rx_shift[bit_pos[2:0]] = 1'b1;
      if (bit_pos == last_bit) begin
        rx = rx_shift;
        bit_pos = '0;
        last_bit = owsrl_pkg::LAST_BIT_BYTE;
        take_byte(rx);
        rx_shift = '0;
      end else begin
        bit_pos = bit_pos + 6'd1;
      end
    end
  endfunction

  function automatic void give_bit();
    logic b;
    int k;
    b = (bit_pos < 6'd8) ? tx_byte[bit_pos[2:0]] : 1'b1;
    if (!b) begin
      pred_res.drive_low = 1'b1;
      pred_res.drive_delay_us = owsrl_pkg::DATA_DELAY_US;
      pred_res.drive_width_us = owsrl_pkg::DATA_WIDTH_US;
    end
    if (bit_pos != last_bit) begin
      bit_pos = bit_pos + 6'd1;
    end else begin
      bit_pos = '0;
      tx_on = 1'b0;
      if (ph == owsrl_pkg::PH_SEARCH) begin
        last_bit = owsrl_pkg::LAST_BIT_FIRST;
      end else if (id_bytes_left != 4'd0) begin
        id_bytes_left = id_bytes_left - 4'd1;
        if (id_bytes_left == 4'd0) begin
          if (ph == owsrl_pkg::PH_ROM_CMD) ph = owsrl_pkg::PH_FUN_CMD;
          else if (ph == owsrl_pkg::PH_FUN_CMD) ph = owsrl_pkg::PH_IDLE;
        end else begin
          k = 8 - id_bytes_left;
          load_tx(dev_id[8*k +: 8], owsrl_pkg::LAST_BIT_BYTE);
        end
      end
    end
  endfunction

  function automatic owsrl_pkg::res_t predict_pulse(input logic [owsrl_pkg::TIME_W-1:0] t);
    pred_res = '0;
    if (t > thr_reset) begin
      rx_shift = '0;
      bit_pos = '0;
      last_bit = owsrl_pkg::LAST_BIT_BYTE;
      tx_on = 1'b0;
      id_bytes_left = '0;
      ph = owsrl_pkg::PH_ROM_CMD;
      pred_res.drive_low = 1'b1;
      pred_res.drive_delay_us = owsrl_pkg::PRESENCE_DELAY_US;
      pred_res.drive_width_us = owsrl_pkg::PRESENCE_WIDTH_US;
    end else if (ph != owsrl_pkg::PH_IDLE) begin
      if (t > thr_zero) begin
        if (!tx_on) take_bit(1'b0);
      end else if (t < thr_one) begin
        if (tx_on) give_bit();
        else take_bit(1'b1);
      end
    end
    pred_res.selected = (ph == owsrl_pkg::PH_FUN_CMD);
    return pred_res;
  endfunction

  task automatic report_mismatch(input string what, input longint seen_v, input longint want_v);
    n_errors++;
    if (n_errors <= REPORT_LIMIT)
      $display("Mismatch on result %0d: %s is %0d, expected %0d", n_checked, what, seen_v, want_v);
  endtask

  // Long idle draws alternate with runs where a side never waits.
  function automatic int draw_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left[side] = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took || !in_tvalid) begin
        if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap--;
        end else if (pending_pulses.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= {{(owsrl_pkg::IN_TDATA_W - owsrl_pkg::TIME_W){1'b0}},
                       pending_pulses.pop_front()};
          send_gap = draw_wait(0);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) recv_stall = draw_wait(1);
      if (recv_stall > 0) begin
        out_tready <= 1'b0;
        recv_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      out_took <= out_tvalid && out_tready;
      if (in_tvalid && in_tready) begin
        pending_results.insert(pending_results.size(),
                               predict_pulse(in_tdata[owsrl_pkg::TIME_W-1:0]));
        n_accepted++;
      end
      if (out_tvalid && out_tready) begin
        seen = owsrl_pkg::res_t'(out_tdata[$bits(owsrl_pkg::res_t)-1:0]);
        if (pending_results.size() == 0) begin
          report_mismatch("result with no pending item", out_tdata, 0);
        end else begin
          want = pending_results.pop_front();
          if (seen.drive_low !== want.drive_low)
            report_mismatch("drive_low", seen.drive_low, want.drive_low);
          if (seen.drive_delay_us !== want.drive_delay_us)
            report_mismatch("drive_delay_us", seen.drive_delay_us, want.drive_delay_us);
          if (seen.drive_width_us !== want.drive_width_us)
            report_mismatch("drive_width_us", seen.drive_width_us, want.drive_width_us);
          if (seen.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", seen.byte_valid, want.byte_valid);
          if (seen.byte_value !== want.byte_value)
            report_mismatch("byte_value", seen.byte_value, want.byte_value);
          if (seen.selected !== want.selected)
            report_mismatch("selected", seen.selected, want.selected);
          n_checked++;
          if (want.drive_low && want.drive_width_us == owsrl_pkg::PRESENCE_WIDTH_US)
            n_presence++;
          else if (want.drive_low) n_pulls++;
          if (want.byte_valid) n_fun_bytes++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("No item moved for %0d cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_time(input int unsigned t, input logic counted);
    pending_pulses.insert(pending_pulses.size(), t[owsrl_pkg::TIME_W-1:0]);
    if (counted) n_queued++;
  endtask

  function automatic int unsigned pick_between(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Pulse of the given class under the current thresholds; any length if none exists.
  task automatic push_class(input int cls, input logic counted);
    int unsigned lo, hi;
    lo = 0;
    hi = TIME_MAX;
    case (cls)
      CLS_RESET: lo = thr_reset + 1;
      CLS_ZERO: begin
        lo = thr_zero + 1;
        hi = thr_reset;
      end
      CLS_ONE: begin
        hi = (thr_zero < thr_reset) ? thr_zero : thr_reset;
        if (thr_one == 0) lo = 1;
        else if (thr_one - 1 < hi) hi = thr_one - 1;
      end
      default: begin
        lo = thr_one;
        hi = (thr_zero < thr_reset) ? thr_zero : thr_reset;
      end
    endcase
    if (lo <= hi) push_time(pick_between(lo, hi), counted);
    else push_time($urandom_range(0, TIME_MAX), counted);
  endtask

  task automatic send_bit(input logic b);
    if ($urandom_range(0, 11) == 0) push_class(CLS_GAP, 1'b0);
    push_class(b ? CLS_ONE : CLS_ZERO, 1'b1);
  endtask

  task automatic send_byte(input logic [7:0] value);
    int i;
    for (i = 0; i < 8; i++) send_bit(value[i]);
  endtask

  task automatic send_function_bytes();
    repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 255));
  endtask

  task automatic bus_transaction();
    int pick, bad, slots, i;
    logic [7:0] cmd;
    pick = $urandom_range(0, 9);
    bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : 64;
    push_class(CLS_RESET, 1'b1);
    if (pick < 2) begin
      seq_count[SEQ_READ]++;
      send_byte(owsrl_pkg::CMD_READ_ROM);
      slots = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 63) : 64;
      for (i = 0; i < slots; i++) begin
        if ($urandom_range(0, 15) == 0) push_class(CLS_ZERO, 1'b0);
        send_bit(1'b1);
      end
      if (slots == 64) send_function_bytes();
    end else if (pick < 4) begin
      seq_count[SEQ_MATCH]++;
      send_byte(owsrl_pkg::CMD_MATCH_ROM);
      for (i = 0; i < 64 && i <= bad; i++) send_bit(i == bad ? ~dev_id[i] : dev_id[i]);
      if (bad == 64) send_function_bytes();
    end else if (pick == 4) begin
      seq_count[SEQ_SEARCH]++;
      send_byte(owsrl_pkg::CMD_SEARCH_ROM);
      for (i = 0; i < 64 && i <= bad; i++) begin
        if ($urandom_range(0, 15) == 0) push_class(CLS_ZERO, 1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
        send_bit(i == bad ? ~dev_id[i] : dev_id[i]);
      end
      if (bad == 64) send_function_bytes();
    end else if (pick < 7) begin
      seq_count[SEQ_SKIP]++;
      send_byte(owsrl_pkg::CMD_SKIP_ROM);
      send_function_bytes();
    end else if (pick == 7) begin
      seq_count[SEQ_UNKNOWN]++;
      do cmd = $urandom_range(0, 255);
      while (cmd == owsrl_pkg::CMD_READ_ROM || cmd == owsrl_pkg::CMD_MATCH_ROM ||
             cmd == owsrl_pkg::CMD_SKIP_ROM || cmd == owsrl_pkg::CMD_SEARCH_ROM);
      send_byte(cmd);
      send_byte($urandom_range(0, 255));
    end else begin
      seq_count[SEQ_NOISE]++;
      repeat ($urandom_range(3, 12)) push_class($urandom_range(CLS_RESET, CLS_GAP), 1'b1);
    end
  endtask

  task automatic random_traffic(input int n);
    int target;
    target = n_queued + n;
    while (n_queued < target) bus_transaction();
  endtask

  task automatic wait_idle();
    while (pending_pulses.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [owsrl_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [owsrl_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
  endtask

  task automatic apply_settings(input logic [63:0] id, input int unsigned r, input int unsigned z,
                                input int unsigned o);
    wait_idle();
    write_reg(owsrl_pkg::REG_ROM_ID, id);
    write_reg(owsrl_pkg::REG_RESET_THRESH, owsrl_pkg::CFG_DATA_W'(r));
    write_reg(owsrl_pkg::REG_ZERO_THRESH, owsrl_pkg::CFG_DATA_W'(z));
    write_reg(owsrl_pkg::REG_ONE_THRESH, owsrl_pkg::CFG_DATA_W'(o));
    @(negedge clk);
    cfg_we <= 1'b0;
    dev_id = id;
    thr_reset = r;
    thr_zero = z;
    thr_one = o;
    n_settings++;
  endtask

  initial begin
    int unsigned one_t, zero_t, reset_t;
    reset_predictor();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    apply_settings({$urandom, $urandom}, owsrl_pkg::RESET_THRESH_DEFAULT,
                   owsrl_pkg::ZERO_THRESH_DEFAULT, owsrl_pkg::ONE_THRESH_DEFAULT);
    // A pulse while idle is ignored; then a full-length reset and skip ROM.
    push_time(0, 1'b1);
    push_time(TIME_MAX, 1'b1);
    send_byte(owsrl_pkg::CMD_SKIP_ROM);
    push_class(CLS_GAP, 1'b1);
    send_byte(8'h5A);
    push_time(thr_reset, 1'b1);
    push_time(thr_reset + 1, 1'b1);
    push_time(thr_zero, 1'b1);
    push_time(thr_one, 1'b1);
    push_time(thr_one - 1, 1'b1);
    push_time(thr_zero + 1, 1'b1);
    random_traffic(370);

    apply_settings({64{1'b1}}, 1000, 500, 600);
    random_traffic(180);
    apply_settings('0, 0, 0, 1);
    random_traffic(45);
    apply_settings({$urandom, $urandom}, TIME_MAX, 0, TIME_MAX);
    random_traffic(45);
    one_t = $urandom_range(50, 40000);
    zero_t = one_t + $urandom_range(0, 40000);
    reset_t = zero_t + $urandom_range(1, 300000);
    apply_settings({$urandom, $urandom}, reset_t, zero_t, one_t);
    random_traffic(190);
    apply_settings({$urandom, $urandom}, owsrl_pkg::RESET_THRESH_DEFAULT,
                   owsrl_pkg::ZERO_THRESH_DEFAULT, owsrl_pkg::ONE_THRESH_DEFAULT);
    random_traffic(270);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d pulses under %0d register settings:",
             n_checked, n_accepted, n_settings);
    $display("  %0d presence, %0d data pulls, %0d function bytes.",
             n_presence, n_pulls, n_fun_bytes);
    $display("Bus sequences: %0d read, %0d match, %0d search, %0d skip, %0d unknown, %0d noise.",
             seq_count[SEQ_READ], seq_count[SEQ_MATCH], seq_count[SEQ_SEARCH],
             seq_count[SEQ_SKIP], seq_count[SEQ_UNKNOWN], seq_count[SEQ_NOISE]);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/owsrl_pkg.sv
rtl/owsrl_cfg.sv
rtl/owsrl_core.sv
rtl/one_wire_slave_rom_layer_unit.sv
tb/sv/one_wire_slave_rom_layer_unit_tb.sv
